// File: rtl/core/otsu_pkg.sv
`default_nettype none
// ============================================================================
// otsu_pkg
// Shared widths, constants and interface structs of the Otsu threshold finder.
// ============================================================================
package otsu_pkg;

    localparam int COUNT_BITS = 20;                     // bin and pixel counter width
    localparam int BIN_W      = 8;                      // gray level width
    localparam int BINS       = 256;
    localparam int SUM_W      = COUNT_BITS + BIN_W;     // intensity sum width
    localparam int X_W        = SUM_W + COUNT_BITS;     // sB*T and S*wB width
    localparam int DEN_W      = 2 * COUNT_BITS;         // wB*wF width
    localparam int NUM_W      = 2 * X_W;                // squared difference width
    localparam int PROD_W     = NUM_W + DEN_W;          // cross product width
    localparam int MPA_W      = X_W;                    // multiplier operand A width
    localparam int MPB_W      = DEN_W;                  // multiplier operand B width
    localparam int STEP_W     = $clog2(X_W + 1);
    localparam int CFG_IDX_W  = 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [BIN_W-1:0] DEFAULT_THRESHOLD = 8'd128;
    localparam logic [BIN_W-1:0] LAST_BIN          = 8'd255;
    localparam logic [BIN_W-1:0] CLAMP_LOW_RESET   = 8'd48;
    localparam logic [BIN_W-1:0] CLAMP_HIGH_RESET  = 8'd224;

    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_HIGH = 1'b1;

    // Scan access to the histogram memory: read one bin and zero it.
    typedef struct packed {
        logic             rd;
        logic [BIN_W-1:0] addr;
    } t_scan_req;

    // Finished scan result, held until the output register takes it.
    typedef struct packed {
        logic             valid;
        logic [BIN_W-1:0] thr;
        logic             found;
    } t_scan_res;

endpackage
`default_nettype wire

// File: rtl/core/otsu_hist.sv
`default_nettype none
// ============================================================================
// otsu_hist
// Histogram memory with forwarded read-modify-write, frame totals, a clearing
// pass after reset, and a read-and-clear port for the threshold scan.
// ============================================================================
module otsu_hist
    import otsu_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_pix_vld,
    input  wire logic [BIN_W-1:0]      i_pix_value,
    input  wire logic                  i_clear_totals,
    input  wire t_scan_req             i_scan_req,
    output logic      [COUNT_BITS-1:0] o_rd_data,
    output logic      [COUNT_BITS-1:0] o_pixel_total,
    output logic      [SUM_W-1:0]      o_intensity_total,
    output logic                       o_ready
);

    logic [COUNT_BITS-1:0] mem [BINS];

    logic                  r_init_busy;
    logic [BIN_W-1:0]      r_init_addr;
    logic                  r_s1_vld;
    logic [BIN_W-1:0]      r_s1_addr;
    logic                  r_fwd_vld;
    logic [BIN_W-1:0]      r_fwd_addr;
    logic [COUNT_BITS-1:0] r_fwd_data;
    logic [COUNT_BITS-1:0] r_rd_data;
    logic [COUNT_BITS-1:0] r_pixel_total;
    logic [SUM_W-1:0]      r_intensity_total;

    logic                  w_counted;
    logic [COUNT_BITS-1:0] w_cur;
    logic [COUNT_BITS-1:0] w_inc;
    logic                  w_rd_en;
    logic [BIN_W-1:0]      w_rd_addr;
    logic                  w_wr_en;
    logic [BIN_W-1:0]      w_wr_addr;
    logic [COUNT_BITS-1:0] w_wr_data;

    // Pixels stop counting once the total is full, so no bin can wrap.
    assign w_counted = i_pix_vld && (r_pixel_total != COUNT_MAX);

    // The write of the previous cycle is not yet visible in the read data.
    assign w_cur = (r_fwd_vld && (r_fwd_addr == r_s1_addr)) ? r_fwd_data : r_rd_data;
    assign w_inc = w_cur + COUNT_BITS'(1);

    assign w_rd_en   = i_pix_vld || i_scan_req.rd;
    assign w_rd_addr = i_scan_req.rd ? i_scan_req.addr : i_pix_value;

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_s1_addr;
        w_wr_data = w_inc;
        if (r_init_busy) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_init_addr;
            w_wr_data = '0;
        end else if (r_s1_vld) begin
            w_wr_en = 1'b1;
        end else if (i_scan_req.rd) begin
            w_wr_en   = 1'b1;
            w_wr_addr = i_scan_req.addr;
            w_wr_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= mem[w_rd_addr];
        end
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_busy       <= 1'b1;
            r_init_addr       <= '0;
            r_s1_vld          <= 1'b0;
            r_fwd_vld         <= 1'b0;
            r_pixel_total     <= '0;
            r_intensity_total <= '0;
        end else begin
            if (r_init_busy) begin
                r_init_addr <= r_init_addr + BIN_W'(1);
                if (r_init_addr == LAST_BIN) begin
                    r_init_busy <= 1'b0;
                end
            end
            r_s1_vld  <= w_counted;
            r_fwd_vld <= r_s1_vld;
            if (i_clear_totals) begin
                r_pixel_total     <= '0;
                r_intensity_total <= '0;
            end else if (w_counted) begin
                r_pixel_total     <= r_pixel_total + COUNT_BITS'(1);
                r_intensity_total <= r_intensity_total + SUM_W'(i_pix_value);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr  <= i_pix_value;
        r_fwd_addr <= r_s1_addr;
        r_fwd_data <= w_inc;
    end

    assign o_rd_data         = r_rd_data;
    assign o_pixel_total     = r_pixel_total;
    assign o_intensity_total = r_intensity_total;
    assign o_ready           = !r_init_busy;

    a_no_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_s1_vld && i_scan_req.rd))
        else $error("pixel update and scan clear hit the memory together");

    a_no_pixel_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_vld |-> !r_init_busy)
        else $error("pixel accepted during the clearing pass");

    a_total_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_clear_totals |=> (r_pixel_total >= $past(r_pixel_total)))
        else $error("pixel total decreased without a clear");

endmodule
`default_nettype wire

// File: rtl/core/otsu_scan.sv
`default_nettype none
// ============================================================================
// otsu_scan
// Threshold scan: walks the histogram bins, and for every valid split runs a
// shift-add multiplier to compare between-class variances exactly.
// ============================================================================
module otsu_scan
    import otsu_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [COUNT_BITS-1:0] i_rd_data,
    input  wire logic [COUNT_BITS-1:0] i_pixel_total,
    input  wire logic [SUM_W-1:0]      i_intensity_total,
    input  wire logic                  i_res_taken,
    output t_scan_req                  o_req,
    output t_scan_res                  o_res
);

    typedef enum logic [10:0] {
        S_IDLE       = 11'b000_0000_0001,
        S_READ       = 11'b000_0000_0010,
        S_ACCUM      = 11'b000_0000_0100,
        S_CHECK      = 11'b000_0000_1000,
        S_MUL_XY     = 11'b000_0001_0000,
        S_DIFF       = 11'b000_0010_0000,
        S_MUL_ND     = 11'b000_0100_0000,
        S_LOAD_CROSS = 11'b000_1000_0000,
        S_MUL_CROSS  = 11'b001_0000_0000,
        S_PICK       = 11'b010_0000_0000,
        S_DONE       = 11'b100_0000_0000
    } t_state;

    t_state                r_state, n_state;
    logic [BIN_W-1:0]      r_t, n_t;
    logic [COUNT_BITS-1:0] r_wb, n_wb;
    logic [SUM_W-1:0]      r_sb, n_sb;
    logic [STEP_W-1:0]     r_step, n_step;
    logic [PROD_W-1:0]     r_acc_a, n_acc_a;
    logic [PROD_W-1:0]     r_acc_b, n_acc_b;
    logic [PROD_W-1:0]     r_mcand_a, n_mcand_a;
    logic [PROD_W-1:0]     r_mcand_b, n_mcand_b;
    logic [MPA_W-1:0]      r_mplier_a, n_mplier_a;
    logic [MPB_W-1:0]      r_mplier_b, n_mplier_b;
    logic [NUM_W-1:0]      r_num, n_num;
    logic [DEN_W-1:0]      r_den, n_den;
    logic [NUM_W-1:0]      r_best_num, n_best_num;
    logic [DEN_W-1:0]      r_best_den, n_best_den;
    logic [BIN_W-1:0]      r_best_t, n_best_t;
    logic                  r_have, n_have;

    logic [SUM_W-1:0]      w_bin_sum;
    logic [X_W-1:0]        w_x;
    logic [X_W-1:0]        w_y;
    logic [X_W-1:0]        w_d;

    assign w_bin_sum = SUM_W'(r_t) * SUM_W'(i_rd_data);
    assign w_x       = r_acc_a[X_W-1:0];
    assign w_y       = r_acc_b[X_W-1:0];
    assign w_d       = (w_x >= w_y) ? (w_x - w_y) : (w_y - w_x);

    always_comb begin
        n_state    = r_state;
        n_t        = r_t;
        n_wb       = r_wb;
        n_sb       = r_sb;
        n_step     = r_step;
        n_acc_a    = r_acc_a;
        n_acc_b    = r_acc_b;
        n_mcand_a  = r_mcand_a;
        n_mcand_b  = r_mcand_b;
        n_mplier_a = r_mplier_a;
        n_mplier_b = r_mplier_b;
        n_num      = r_num;
        n_den      = r_den;
        n_best_num = r_best_num;
        n_best_den = r_best_den;
        n_best_t   = r_best_t;
        n_have     = r_have;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_t     = '0;
                    n_wb    = '0;
                    n_sb    = '0;
                    n_have  = 1'b0;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_ACCUM;
            end
            S_ACCUM: begin
                n_wb = r_wb + i_rd_data;
                n_sb = r_sb + w_bin_sum;
                // The top bin is only read to clear it; it is never a candidate.
                n_state = (r_t == LAST_BIN) ? S_DONE : S_CHECK;
            end
            S_CHECK: begin
                if ((r_wb == '0) || (r_wb >= i_pixel_total)) begin
                    n_t     = r_t + BIN_W'(1);
                    n_state = S_READ;
                end else begin
                    n_acc_a    = '0;
                    n_acc_b    = '0;
                    n_mcand_a  = PROD_W'(r_sb);
                    n_mplier_a = MPA_W'(i_pixel_total);
                    n_mcand_b  = PROD_W'(i_intensity_total);
                    n_mplier_b = MPB_W'(r_wb);
                    n_step     = STEP_W'(COUNT_BITS);
                    n_state    = S_MUL_XY;
                end
            end
            S_MUL_XY, S_MUL_ND, S_MUL_CROSS: begin
                n_acc_a    = r_acc_a + (r_mplier_a[0] ? r_mcand_a : '0);
                n_acc_b    = r_acc_b + (r_mplier_b[0] ? r_mcand_b : '0);
                n_mcand_a  = r_mcand_a << 1;
                n_mcand_b  = r_mcand_b << 1;
                n_mplier_a = r_mplier_a >> 1;
                n_mplier_b = r_mplier_b >> 1;
                n_step     = r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    case (r_state)
                        S_MUL_XY:  n_state = S_DIFF;
                        S_MUL_ND:  n_state = S_LOAD_CROSS;
                        default:   n_state = S_PICK;
                    endcase
                end
            end
            S_DIFF: begin
                // Squared difference and wB*wF run side by side.
                n_acc_a    = '0;
                n_acc_b    = '0;
                n_mcand_a  = PROD_W'(w_d);
                n_mplier_a = w_d;
                n_mcand_b  = PROD_W'(r_wb);
                n_mplier_b = MPB_W'(i_pixel_total - r_wb);
                n_step     = STEP_W'(X_W);
                n_state    = S_MUL_ND;
            end
            S_LOAD_CROSS: begin
                n_num = r_acc_a[NUM_W-1:0];
                n_den = r_acc_b[DEN_W-1:0];
                if (r_have) begin
                    n_acc_a    = '0;
                    n_acc_b    = '0;
                    n_mcand_a  = PROD_W'(r_acc_a[NUM_W-1:0]);
                    n_mplier_a = MPA_W'(r_best_den);
                    n_mcand_b  = PROD_W'(r_best_num);
                    n_mplier_b = r_acc_b[DEN_W-1:0];
                    n_step     = STEP_W'(DEN_W);
                    n_state    = S_MUL_CROSS;
                end else begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                // Strictly larger wins, so the first maximum is kept.
                if (!r_have || (r_acc_a > r_acc_b)) begin
                    n_best_num = r_num;
                    n_best_den = r_den;
                    n_best_t   = r_t;
                    n_have     = 1'b1;
                end
                n_t     = r_t + BIN_W'(1);
                n_state = S_READ;
            end
            S_DONE: begin
                if (i_res_taken) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t        <= n_t;
        r_wb       <= n_wb;
        r_sb       <= n_sb;
        r_step     <= n_step;
        r_acc_a    <= n_acc_a;
        r_acc_b    <= n_acc_b;
        r_mcand_a  <= n_mcand_a;
        r_mcand_b  <= n_mcand_b;
        r_mplier_a <= n_mplier_a;
        r_mplier_b <= n_mplier_b;
        r_num      <= n_num;
        r_den      <= n_den;
        r_best_num <= n_best_num;
        r_best_den <= n_best_den;
        r_best_t   <= n_best_t;
        r_have     <= n_have;
    end

    assign o_req.rd    = (r_state == S_READ);
    assign o_req.addr  = r_t;
    assign o_res.valid = (r_state == S_DONE);
    assign o_res.thr   = r_have ? r_best_t : DEFAULT_THRESHOLD;
    assign o_res.found = r_have;

endmodule
`default_nettype wire

// File: rtl/core/otsu_threshold_finder.sv
`default_nettype none
// ============================================================================
// otsu_threshold_finder
// Otsu threshold over an 8-bit gray-level histogram, one result per frame.
// ============================================================================
// Pixels enter on the input channel (i_in_valid / o_in_ready), one transaction
// per cycle while input ready is high, and each counted pixel updates its bin
// by a forwarded read-modify-write of the histogram memory. The transaction
// that carries i_last_pixel closes the frame: input ready drops, the start is
// registered in r_start, and the scan then leaves S_IDLE. For each threshold
// the scan reads, accumulates and checks the bin; each valid split also runs
// the bit-serial shift-add multiplier (COUNT_BITS, X_W and DEN_W steps for the
// three products of a candidate, the cross product only once a best exists).
// The scan zeroes every bin as it reads it, so the next frame may start as
// soon as the result moves into the output register, even if the receiver is
// still stalling (o_out_valid held until i_out_ready). Only a second finished
// frame waits. After reset a clearing pass zeroes the memory; input ready is
// low during it. Clamp bounds are written on the configuration channel, which
// is always ready, and reset to 48 and 224.
// ============================================================================
module otsu_threshold_finder
    import otsu_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [BIN_W-1:0]     i_pixel_value,
    input  wire logic                 i_last_pixel,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic      [BIN_W-1:0]     o_threshold,
    output logic                      o_split_found,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [BIN_W-1:0]     i_cfg_data
);

    logic [BIN_W-1:0]      r_clamp_low;
    logic [BIN_W-1:0]      r_clamp_high;
    logic                  r_busy;
    logic                  r_start;
    logic                  r_out_valid;
    logic [BIN_W-1:0]      r_threshold;
    logic                  r_split_found;

    logic                  w_in_acc;
    logic                  w_hist_ready;
    logic                  w_handoff;
    logic [BIN_W-1:0]      w_thr_lo;
    logic [BIN_W-1:0]      w_thr;
    logic [COUNT_BITS-1:0] w_rd_data;
    logic [COUNT_BITS-1:0] w_pixel_total;
    logic [SUM_W-1:0]      w_intensity_total;
    t_scan_req             w_scan_req;
    t_scan_res             w_scan_res;

    assign o_in_ready  = w_hist_ready && !r_busy;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_handoff   = w_scan_res.valid && (!r_out_valid || i_out_ready);
    assign o_cfg_ready = 1'b1;

    // Raise to the low bound first, so the high bound wins when they cross.
    assign w_thr_lo = (w_scan_res.thr < r_clamp_low) ? r_clamp_low : w_scan_res.thr;
    assign w_thr    = (w_thr_lo > r_clamp_high) ? r_clamp_high : w_thr_lo;

    otsu_hist u_hist (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_pix_vld         (w_in_acc),
        .i_pix_value       (i_pixel_value),
        .i_clear_totals    (w_handoff),
        .i_scan_req        (w_scan_req),
        .o_rd_data         (w_rd_data),
        .o_pixel_total     (w_pixel_total),
        .o_intensity_total (w_intensity_total),
        .o_ready           (w_hist_ready)
    );

    otsu_scan u_scan (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (r_start),
        .i_rd_data         (w_rd_data),
        .i_pixel_total     (w_pixel_total),
        .i_intensity_total (w_intensity_total),
        .i_res_taken       (w_handoff),
        .o_req             (w_scan_req),
        .o_res             (w_scan_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp_low  <= CLAMP_LOW_RESET;
            r_clamp_high <= CLAMP_HIGH_RESET;
            r_busy       <= 1'b0;
            r_start      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_CLAMP_LOW:  r_clamp_low  <= i_cfg_data;
                    CFG_CLAMP_HIGH: r_clamp_high <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            // Register the start so the final bin write lands before the scan reads.
            r_start <= w_in_acc && i_last_pixel;
            if (w_in_acc && i_last_pixel) begin
                r_busy <= 1'b1;
            end else if (w_handoff) begin
                r_busy <= 1'b0;
            end
            if (w_handoff) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_handoff) begin
            r_threshold   <= w_thr;
            r_split_found <= w_scan_res.found;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_threshold   = r_threshold;
    assign o_split_found = r_split_found;

    a_last_closes_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_last_pixel) |=> !o_in_ready)
        else $error("input still ready after the last pixel of a frame");

    a_no_input_during_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan_res.valid |-> !o_in_ready)
        else $error("input ready while a scan result is pending");

    a_handoff_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_handoff |=> o_out_valid)
        else $error("scan result taken but output not valid");

endmodule
`default_nettype wire

// File: test/otsu_threshold_checker.sv
// ============================================================================
// otsu_threshold_checker
// Watches the pixel, result and clamp channels of the Otsu threshold finder.
// ============================================================================
// Every accepted pixel transaction is added to a local histogram until the
// pixel counter is full. The transaction that closes a frame triggers an exact
// integer threshold search. Its clamped result is queued and compared, field
// by field, with the next result transaction. The count of mismatches and of
// outstanding results is handed to the testbench top.
// ============================================================================
module otsu_threshold_checker
    import otsu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [BIN_W-1:0]     i_pixel_value,
    input  logic                 i_last_pixel,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [BIN_W-1:0]     i_threshold,
    input  logic                 i_split_found,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BIN_W-1:0]     i_cfg_data,
    output int                   o_mismatches,
    output int                   o_outstanding,
    output int                   o_results_checked
);

    typedef struct packed {
        logic [BIN_W-1:0] thr;
        logic             found;
    } t_split;

    logic [COUNT_BITS-1:0] bin_count [BINS];
    logic [COUNT_BITS-1:0] pixel_total;
    logic [SUM_W-1:0]      intensity_total;
    logic [BIN_W-1:0]      clamp_low;
    logic [BIN_W-1:0]      clamp_high;
    t_split                threshold_due [$];
    int                    mismatch_count = 0;
    int                    results_checked = 0;

    // The between-class variance (sB*T - S*wB)^2 / (wB*wF) is compared by
    // cross-multiplication, so the search stays exact. Only a strictly larger
    // candidate replaces the current best.
    function automatic t_split search_split();
        logic [COUNT_BITS-1:0] w_back;
        logic [COUNT_BITS-1:0] w_fore;
        logic [SUM_W-1:0]      s_back;
        logic [X_W-1:0]        lhs;
        logic [X_W-1:0]        rhs;
        logic [X_W-1:0]        diff;
        logic [NUM_W-1:0]      num;
        logic [NUM_W-1:0]      best_num;
        logic [DEN_W-1:0]      den;
        logic [DEN_W-1:0]      best_den;
        logic [PROD_W-1:0]     cand_cross;
        logic [PROD_W-1:0]     best_cross;
        t_split                res;
        int                    t;
        w_back    = '0;
        s_back    = '0;
        best_num  = '0;
        best_den  = DEN_W'(1);
        res.thr   = DEFAULT_THRESHOLD;
        res.found = 1'b0;
        for (t = 0; t < LAST_BIN; t++) begin
            w_back = w_back + bin_count[t];
            s_back = s_back + SUM_W'(t) * SUM_W'(bin_count[t]);
            if (w_back != 0 && w_back < pixel_total) begin
                w_fore     = pixel_total - w_back;
                lhs        = X_W'(s_back) * X_W'(pixel_total);
                rhs        = X_W'(intensity_total) * X_W'(w_back);
                diff       = (lhs >= rhs) ? lhs - rhs : rhs - lhs;
                num        = NUM_W'(diff) * NUM_W'(diff);
                den        = DEN_W'(w_back) * DEN_W'(w_fore);
                cand_cross = PROD_W'(num) * PROD_W'(best_den);
                best_cross = PROD_W'(best_num) * PROD_W'(den);
                if (!res.found || cand_cross > best_cross) begin
                    best_num  = num;
                    best_den  = den;
                    res.thr   = t[BIN_W-1:0];
                    res.found = 1'b1;
                end
            end
        end
        // Raise to the low bound first, so the high bound wins when crossed.
        if (res.thr < clamp_low) res.thr = clamp_low;
        if (res.thr > clamp_high) res.thr = clamp_high;
        return res;
    endfunction

    always @(posedge i_clk) begin : track
        t_split due;
        if (!i_rst_n) begin
            for (int b = 0; b < BINS; b++) bin_count[b] = '0;
            pixel_total     = '0;
            intensity_total = '0;
            clamp_low       = CLAMP_LOW_RESET;
            clamp_high      = CLAMP_HIGH_RESET;
            threshold_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_CLAMP_LOW) clamp_low = i_cfg_data;
                else if (i_cfg_index == CFG_CLAMP_HIGH) clamp_high = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                if (threshold_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result transaction with no frame pending, got thr %0d found %0b",
                             $time, i_threshold, i_split_found);
                end else begin
                    due = threshold_due.pop_front();
                    results_checked++;
                    if (i_threshold !== due.thr) begin
                        mismatch_count++;
                        $display("%0t: threshold mismatch, expected %0d, got %0d",
                                 $time, due.thr, i_threshold);
                    end
                    if (i_split_found !== due.found) begin
                        mismatch_count++;
                        $display("%0t: split_found mismatch, expected %0b, got %0b",
                                 $time, due.found, i_split_found);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                // A full pixel counter freezes the histogram and both totals.
                if (pixel_total < COUNT_MAX) begin
                    bin_count[i_pixel_value] = bin_count[i_pixel_value] + COUNT_BITS'(1);
                    pixel_total              = pixel_total + COUNT_BITS'(1);
                    intensity_total          = intensity_total + SUM_W'(i_pixel_value);
                end
                if (i_last_pixel) begin
                    threshold_due = {threshold_due, search_split()};
                    for (int b = 0; b < BINS; b++) bin_count[b] = '0;
                    pixel_total     = '0;
                    intensity_total = '0;
                end
            end
        end
        o_outstanding     <= threshold_due.size();
        o_mismatches      <= mismatch_count;
        o_results_checked <= results_checked;
    end

endmodule

// File: test/testbench.sv
// ============================================================================
// testbench
// Stimulus and verdict for the Otsu threshold finder.
// ============================================================================
// Directed frames cover empty splits, a frame of only level 255, the widest
// and narrowest splits and crossed clamp bounds. Random frames follow in four
// pacing phases with different clamp settings. The checker beside the block
// predicts and compares every result.
// ============================================================================
module testbench;
    import otsu_pkg::*;

    localparam int CYCLE_LIMIT   = 12_000_000;
    localparam int PHASE_PIXELS  = 345;
    localparam int SETTLE_CYCLES = 50;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 in_valid      = 1'b0;
    logic                 in_ready;
    logic [BIN_W-1:0]     pixel_value   = '0;
    logic                 last_pixel    = 1'b0;
    logic                 out_valid;
    logic                 out_ready     = 1'b0;
    logic [BIN_W-1:0]     threshold;
    logic                 split_found;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [BIN_W-1:0]     cfg_data      = '0;

    int mismatches;
    int outstanding;
    int results_checked;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int pixels_sent    = 0;
    int frames_sent    = 0;
    int clamp_writes   = 0;

    always #5 clk = ~clk;

    otsu_threshold_finder u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_pixel_value (pixel_value),
        .i_last_pixel  (last_pixel),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_threshold   (threshold),
        .o_split_found (split_found),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    otsu_threshold_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_pixel_value     (pixel_value),
        .i_last_pixel      (last_pixel),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_threshold       (threshold),
        .i_split_found     (split_found),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_mismatches      (mismatches),
        .o_outstanding     (outstanding),
        .o_results_checked (results_checked)
    );

    always @(posedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Valid stays high from one transaction to the next unless an idle cycle
    // is drawn, so back-to-back pixels never toggle it within a step.
    task automatic send_pixel(input logic [BIN_W-1:0] value, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        pixel_value <= value;
        last_pixel  <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pixels_sent++;
        if (last) frames_sent++;
    endtask

    task automatic write_clamp(input logic [CFG_IDX_W-1:0] index, input logic [BIN_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        clamp_writes++;
        @(posedge clk);
    endtask

    task automatic set_clamps(input logic [BIN_W-1:0] low, input logic [BIN_W-1:0] high);
        write_clamp(CFG_CLAMP_LOW, low);
        write_clamp(CFG_CLAMP_HIGH, high);
    endtask

    // The outstanding count is registered, so it is read only from the edge
    // after the last pixel transaction onward.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Most frames keep their gray levels in a narrow band, which keeps the
    // scan short; a few span the whole range or hold a single level.
    task automatic send_random_frame(output int unsigned sent);
        int unsigned      len;
        int unsigned      base;
        int unsigned      spread;
        int unsigned      shape;
        int unsigned      k;
        logic [BIN_W-1:0] value;
        shape = $urandom_range(0, 9);
        len   = (shape == 9) ? $urandom_range(40, 120) : $urandom_range(1, 40);
        if (shape == 0) begin
            base   = 0;
            spread = 255;
        end else if (shape == 1) begin
            base   = $urandom_range(0, 255);
            spread = 0;
        end else begin
            spread = $urandom_range(1, (shape < 4) ? 64 : 20);
            base   = $urandom_range(0, 255 - spread);
        end
        for (k = 0; k < len; k++) begin
            if (shape < 4 && $urandom_range(0, 1))
                value = BIN_W'($urandom_range(0, 1) ? base : base + spread);
            else
                value = BIN_W'(base + $urandom_range(0, spread));
            send_pixel(value, k == len - 1);
        end
        sent = len;
    endtask

    task automatic random_phase(input int idle_pct, input int stall_pct,
                                input logic [BIN_W-1:0] low, input logic [BIN_W-1:0] high);
        int unsigned phase_pixels;
        int unsigned sent;
        phase_pixels = 0;
        set_clamps(low, high);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (phase_pixels < PHASE_PIXELS) begin
            send_random_frame(sent);
            phase_pixels += sent;
        end
        drain();
    endtask

    initial begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reset clamp bounds: a lone pixel and a frame of only level 255 have
        // no split, and the widest split falls below the low bound.
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd10, 1'b0);
        send_pixel(8'd10, 1'b0);
        send_pixel(8'd200, 1'b0);
        send_pixel(8'd201, 1'b1);
        drain();

        set_clamps(8'd0, 8'd255);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd254, 1'b0);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd50, 1'b0);
        send_pixel(8'd100, 1'b0);
        send_pixel(8'd100, 1'b0);
        send_pixel(8'd200, 1'b0);
        send_pixel(8'd7, 1'b1);
        drain();

        // Crossed bounds: the high bound wins.
        set_clamps(8'd255, 8'd0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b1);
        drain();
        set_clamps(8'd255, 8'd255);
        send_pixel(8'd10, 1'b0);
        send_pixel(8'd20, 1'b0);
        send_pixel(8'd30, 1'b1);
        drain();

        random_phase(0, 0, 8'd0, 8'd255);
        random_phase(75, 0, 8'd60, 8'd190);
        random_phase(0, 75, 8'd200, 8'd80);
        random_phase(12, 12, 8'd20, 8'd240);

        $display("Summary: %0d pixels in %0d frames, %0d results compared, %0d clamp writes.",
                 pixels_sent, frames_sent, results_checked, clamp_writes);
        $display("Summary: directed split and clamp frames plus four pacing phases.");
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
